// ===== rtl/core/wavhp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser package
// Tags, limits, status codes, parse phases and the result record shared by
// the parse core and the stream wrapper.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  // Four-character tags as they assemble little-endian from the byte stream.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_FILE  = 32'd44;
  localparam logic [15:0] NEED_BITS = 16'd16;

  // Packed result width and the byte-rounded stream width.
  localparam int RESULT_BITS = 3 + 16 + 32 + 32 + 32;
  localparam int RESULT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

  typedef enum logic [4:0] {
    PH_TAGS   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_PAD    = 5'b01000,
    PH_STOP   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    TE_NONE = 2'd0,
    TE_RIFF = 2'd1,
    TE_WAVE = 2'd2
  } tag_err_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_RIFF  = 3'd2,
    ST_BAD_WAVE  = 3'd3,
    ST_NO_DATA   = 3'd4,
    ST_NOT_PCM   = 3'd5,
    ST_NOT_16BIT = 3'd6,
    ST_BAD_CHAN  = 3'd7
  } status_t;

  typedef struct packed {
    logic [31:0] data_size;
    logic [31:0] data_offset;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    status_t     status;
  } wavhp_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/wavhp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parse core
// Holds the parse state and applies one file byte per step; flags the step
// that carries the final byte and presents the result for it.
// ----------------------------------------------------------------------------
module wavhp_core
  import wavhp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    data_byte,
  input  wire logic [31:0]   file_length,
  output logic               res_valid,
  output wavhp_result_t      result
);

  // Body offsets of the last byte of each fmt field.
  localparam logic [4:0] OFS_FORMAT   = 5'd1;
  localparam logic [4:0] OFS_CHANNELS = 5'd3;
  localparam logic [4:0] OFS_RATE     = 5'd7;
  localparam logic [4:0] OFS_BITS     = 5'd15;
  localparam logic [4:0] OFS_SAT      = 5'd16;

  logic [31:0] byte_position;
  phase_t      phase,           phase_next;
  logic        is_fmt,          is_fmt_next;
  logic        is_data,         is_data_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [4:0]  body_index,      body_index_next;
  logic        pad_pending,     pad_pending_next;
  logic [31:0] field_assembly,  field_assembly_next;
  tag_err_t    tag_error,       tag_error_next;
  logic [15:0] format_kept,     format_kept_next;
  logic [15:0] channels_kept,   channels_kept_next;
  logic [15:0] bits_kept,       bits_kept_next;
  logic [31:0] rate_kept,       rate_kept_next;
  logic [31:0] data_start_kept, data_start_kept_next;
  logic [31:0] data_size_kept,  data_size_kept_next;
  logic        data_seen,       data_seen_next;
  logic [2:0]  header_count,    header_count_next;

  logic [32:0] len_ext;
  logic        header_short;
  logic        size_over;
  logic        last_byte;
  logic        fields_on;
  logic [31:0] pos_plus1;

  always_comb begin
    phase_next           = phase;
    is_fmt_next          = is_fmt;
    is_data_next         = is_data;
    chunk_remaining_next = chunk_remaining;
    body_index_next      = body_index;
    pad_pending_next     = pad_pending;
    tag_error_next       = tag_error;
    format_kept_next     = format_kept;
    channels_kept_next   = channels_kept;
    bits_kept_next       = bits_kept;
    rate_kept_next       = rate_kept;
    data_start_kept_next = data_start_kept;
    data_size_kept_next  = data_size_kept;
    data_seen_next       = data_seen;
    header_count_next    = header_count;

    field_assembly_next = {data_byte, field_assembly[31:8]};
    pos_plus1 = byte_position + 32'd1;
    // A length of zero stands for a full 2^32-byte file.
    len_ext = (file_length == 32'd0) ? {1'b1, 32'd0} : {1'b0, file_length};
    header_short = ({1'b0, byte_position} + 33'd8) > len_ext;
    size_over = ({2'b00, byte_position} + 34'd1 + {2'b00, field_assembly_next})
                > {1'b0, len_ext};

    unique case (phase)
      PH_TAGS: begin
        if (byte_position == 32'd3 && field_assembly_next != TAG_RIFF) begin
          tag_error_next = TE_RIFF;
          phase_next     = PH_STOP;
        end else if (byte_position == 32'd11) begin
          if (field_assembly_next != TAG_WAVE) begin
            tag_error_next = TE_WAVE;
            phase_next     = PH_STOP;
          end else begin
            phase_next        = PH_HEADER;
            header_count_next = 3'd0;
          end
        end
      end
      PH_HEADER: begin
        if (header_count == 3'd0 && header_short) begin
          phase_next = PH_STOP;
        end else begin
          header_count_next = header_count + 3'd1;
          if (header_count == 3'd3) begin
            is_fmt_next  = (field_assembly_next == TAG_FMT);
            is_data_next = (field_assembly_next == TAG_DATA);
          end
          if (header_count == 3'd7) begin
            header_count_next = 3'd0;
            if (size_over) begin
              phase_next = PH_STOP;
            end else begin
              chunk_remaining_next = field_assembly_next;
              pad_pending_next     = field_assembly_next[0];
              body_index_next      = 5'd0;
              if (is_data) begin
                data_start_kept_next = pos_plus1;
                data_size_kept_next  = field_assembly_next;
                data_seen_next       = 1'b1;
              end
              phase_next = (field_assembly_next == 32'd0) ? PH_HEADER : PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        if (is_fmt) begin
          if (body_index == OFS_FORMAT) begin
            format_kept_next = field_assembly_next[31:16];
          end else if (body_index == OFS_CHANNELS) begin
            channels_kept_next = field_assembly_next[31:16];
          end else if (body_index == OFS_RATE) begin
            rate_kept_next = field_assembly_next;
          end else if (body_index == OFS_BITS) begin
            bits_kept_next = field_assembly_next[31:16];
          end
        end
        if (body_index != OFS_SAT) begin
          body_index_next = body_index + 5'd1;
        end
        chunk_remaining_next = chunk_remaining - 32'd1;
        if (chunk_remaining == 32'd1) begin
          phase_next        = pad_pending ? PH_PAD : PH_HEADER;
          header_count_next = 3'd0;
        end
      end
      PH_PAD: begin
        pad_pending_next  = 1'b0;
        phase_next        = PH_HEADER;
        header_count_next = 3'd0;
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase

    last_byte = (pos_plus1 == file_length);
    res_valid = last_byte;

    fields_on = 1'b1;
    if (file_length != 32'd0 && file_length < MIN_FILE) begin
      result.status = ST_SHORT;
      fields_on     = 1'b0;
    end else if (tag_error_next == TE_RIFF) begin
      result.status = ST_BAD_RIFF;
      fields_on     = 1'b0;
    end else if (tag_error_next == TE_WAVE) begin
      result.status = ST_BAD_WAVE;
      fields_on     = 1'b0;
    end else if (!data_seen_next || data_size_kept_next == 32'd0) begin
      result.status = ST_NO_DATA;
    end else if (format_kept_next != 16'd1) begin
      result.status = ST_NOT_PCM;
    end else if (bits_kept_next != NEED_BITS) begin
      result.status = ST_NOT_16BIT;
    end else if (channels_kept_next != 16'd1 && channels_kept_next != 16'd2) begin
      result.status = ST_BAD_CHAN;
    end else begin
      result.status = ST_OK;
    end
    result.channel_count = fields_on ? channels_kept_next   : 16'd0;
    result.sample_rate   = fields_on ? rate_kept_next       : 32'd0;
    result.data_offset   = fields_on ? data_start_kept_next : 32'd0;
    result.data_size     = fields_on ? data_size_kept_next  : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_position   <= 32'd0;
      phase           <= PH_TAGS;
      is_fmt          <= 1'b0;
      is_data         <= 1'b0;
      chunk_remaining <= 32'd0;
      body_index      <= 5'd0;
      pad_pending     <= 1'b0;
      field_assembly  <= 32'd0;
      tag_error       <= TE_NONE;
      format_kept     <= 16'd0;
      channels_kept   <= 16'd0;
      bits_kept       <= 16'd0;
      rate_kept       <= 32'd0;
      data_start_kept <= 32'd0;
      data_size_kept  <= 32'd0;
      data_seen       <= 1'b0;
      header_count    <= 3'd0;
    end else if (step) begin
      byte_position   <= pos_plus1;
      phase           <= phase_next;
      is_fmt          <= is_fmt_next;
      is_data         <= is_data_next;
      chunk_remaining <= chunk_remaining_next;
      body_index      <= body_index_next;
      pad_pending     <= pad_pending_next;
      field_assembly  <= field_assembly_next;
      tag_error       <= tag_error_next;
      format_kept     <= format_kept_next;
      channels_kept   <= channels_kept_next;
      bits_kept       <= bits_kept_next;
      rate_kept       <= rate_kept_next;
      data_start_kept <= data_start_kept_next;
      data_size_kept  <= data_size_kept_next;
      data_seen       <= data_seen_next;
      header_count    <= header_count_next;
    end
  end

`ifndef ASSERT_OFF
  // A result ends the file: the next byte starts over at position zero.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (step && last_byte) |=> (byte_position == 32'd0 && phase == PH_TAGS))
    else $error("parse state not cleared after final byte");

  // The body phase always has bytes left to consume.
  a_body_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (chunk_remaining != 32'd0))
    else $error("body phase with no bytes remaining");

  // A tag failure always stops the walk.
  a_tag_stop: assert property (@(posedge clk) disable iff (rst)
    (tag_error != TE_NONE) |-> (phase == PH_STOP))
    else $error("tag error without stopped walk");

  // The header byte count runs only while a chunk header is read.
  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    (header_count != 3'd0) |-> (phase == PH_HEADER))
    else $error("header count active outside header phase");

  // The pad phase is entered only after an odd chunk size.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAD) |-> pad_pending)
    else $error("pad phase without pending pad byte");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/wav_header_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser
// Stream wrapper around the parse core: input beat register, length register
// and a result register toward the master side.
// ----------------------------------------------------------------------------
// The block takes a WAV file as a stream of byte beats and gives one result
// beat when the final byte of the file (as set by the file_length register)
// has been taken. Each byte is held in an input register and then applied
// to the parse state by a single pass of logic whose result is captured in
// the output register, so the block sustains one byte per clock cycle while
// the master side keeps up. The result beat is offered from the result
// register, once the final byte has passed the input register and the core.
// The only thing that slows intake is a result that is still waiting on the
// master side while the byte behind it is in the input register; intake
// resumes in the cycle that result is taken. After a result the parse state
// returns to its reset values and the next byte starts a new file; the
// length register keeps its value. Write file_length only while no file is
// in progress. A value of zero means a 2^32-byte file.
// ----------------------------------------------------------------------------
module wav_header_parser
  import wavhp_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Configuration: file length in bytes.
  input  wire logic                       cfg_wen,
  input  wire logic [31:0]                cfg_wdata,
  // Slave side: tdata = data_byte[7:0].
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,
  // Master side: tdata = status[2:0], channel_count[18:3], sample_rate[50:19],
  // data_offset[82:51], data_size[114:83], zero fill above.
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [RESULT_TDATA_W-1:0]       m_tdata
);

  logic [31:0]   file_length;
  logic          in_valid;
  logic [7:0]    in_byte;
  logic          step;
  logic          res_valid;
  wavhp_result_t result;

  // A byte is applied once the result register can take whatever it causes.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= 32'd1;
    end else if (cfg_wen) begin
      file_length <= cfg_wdata;
    end
  end

  // Input beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  wavhp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (in_byte),
    .file_length (file_length),
    .res_valid   (res_valid),
    .result      (result)
  );

  // Result register; it holds its beat until the master side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      m_tdata <= {{(RESULT_TDATA_W - RESULT_BITS){1'b0}}, result};
    end
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Streams generated WAV files byte by byte into the parser and checks every
// result beat against a cycle-free model of the header walk kept here.
// ----------------------------------------------------------------------------
module tb;
  import wavhp_pkg::*;

  // Run sizing. The quiet limit is many times the longest legal silence: the
  // long sink hold plus the longest source gap.
  localparam int ITEM_TARGET = 1600;
  localparam int FILE_TARGET = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;

  // Chunk kinds used by the file generator.
  localparam int CK_FMT   = 0;
  localparam int CK_DATA  = 1;
  localparam int CK_OTHER = 2;

  // Tags for filler chunks that the parser has to skip.
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_JUNK = 32'h6B6E_756A;

  // --------------------------------------------------------------------------
  // Header tracker: follows the parse of the file being streamed and keeps
  // the results that finished files must produce, oldest first.
  // --------------------------------------------------------------------------
  class wav_header_tracker;
    logic [31:0]   file_len;
    logic [31:0]   position;
    logic [31:0]   window;       // last four bytes, newest in the top byte
    logic [31:0]   chunk_tag;
    logic [31:0]   chunk_len;
    logic [31:0]   chunk_left;
    logic [31:0]   rate;
    logic [31:0]   data_start;
    logic [31:0]   data_bytes;
    logic [15:0]   fmt_code;
    logic [15:0]   channels;
    logic [15:0]   sample_bits;
    phase_t        phase;
    tag_err_t      tag_fault;
    bit            pad_due;
    bit            data_found;
    int unsigned   hdr_bytes;
    wavhp_result_t pending_headers[$];
    int            failures;

    function new();
      file_len = 32'd1;
      failures = 0;
      restart();
    endfunction

    // Parse state goes back to its reset values; the length register stays.
    function void restart();
      position   = '0;
      window     = '0;
      chunk_tag  = '0;
      chunk_len  = '0;
      chunk_left = '0;
      rate       = '0;
      data_start = '0;
      data_bytes = '0;
      fmt_code   = '0;
      channels   = '0;
      sample_bits = '0;
      phase      = PH_TAGS;
      tag_fault  = TE_NONE;
      pad_due    = 1'b0;
      data_found = 1'b0;
      hdr_bytes  = 0;
    endfunction

    function void set_length(logic [31:0] value);
      file_len = value;
    endfunction

    function int pending();
      return pending_headers.size();
    endfunction

    function void absorb_byte(logic [7:0] value);
      longint unsigned pos;
      longint unsigned span;
      logic [31:0]     offset;
      wavhp_result_t   hdr;
      pos  = position;
      span = (file_len == 0) ? 64'h1_0000_0000 : file_len;
      window = {value, window[31:8]};
      case (phase)
        PH_TAGS: begin
          if (pos == 3 && window != TAG_RIFF) begin
            tag_fault = TE_RIFF;
            phase = PH_STOP;
          end else if (pos == 11) begin
            if (window != TAG_WAVE) begin
              tag_fault = TE_WAVE;
              phase = PH_STOP;
            end else begin
              phase = PH_HEADER;
              hdr_bytes = 0;
            end
          end
        end
        PH_HEADER: begin
          if (hdr_bytes == 0 && pos + 8 > span) begin
            phase = PH_STOP;
          end else begin
            hdr_bytes++;
            if (hdr_bytes == 4) begin
              chunk_tag = window;
            end else if (hdr_bytes >= 8) begin
              hdr_bytes = 0;
              if (pos + 1 + window > span) begin
                phase = PH_STOP;
              end else begin
                chunk_len  = window;
                chunk_left = window;
                pad_due    = window[0];
                if (chunk_tag == TAG_DATA) begin
                  data_start = position + 32'd1;
                  data_bytes = window;
                  data_found = 1'b1;
                end
                phase = (window == 0) ? PH_HEADER : PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          offset = chunk_len - chunk_left;
          if (chunk_tag == TAG_FMT) begin
            case (offset)
              32'd1:  fmt_code = window[31:16];
              32'd3:  channels = window[31:16];
              32'd7:  rate = window;
              32'd15: sample_bits = window[31:16];
              default: ;
            endcase
          end
          chunk_left--;
          if (chunk_left == 0) begin
            phase = pad_due ? PH_PAD : PH_HEADER;
            hdr_bytes = 0;
          end
        end
        PH_PAD: begin
          pad_due = 1'b0;
          phase = PH_HEADER;
          hdr_bytes = 0;
        end
        default: ;
      endcase

      if (position + 32'd1 != file_len) begin
        position++;
        return;
      end

      hdr = '0;
      if (span < MIN_FILE) begin
        hdr.status = ST_SHORT;
      end else if (tag_fault == TE_RIFF) begin
        hdr.status = ST_BAD_RIFF;
      end else if (tag_fault == TE_WAVE) begin
        hdr.status = ST_BAD_WAVE;
      end else begin
        hdr.channel_count = channels;
        hdr.sample_rate   = rate;
        hdr.data_offset   = data_start;
        hdr.data_size     = data_bytes;
        if (!data_found || data_bytes == 0) hdr.status = ST_NO_DATA;
        else if (fmt_code != 16'd1) hdr.status = ST_NOT_PCM;
        else if (sample_bits != NEED_BITS) hdr.status = ST_NOT_16BIT;
        else if (channels != 16'd1 && channels != 16'd2) hdr.status = ST_BAD_CHAN;
        else hdr.status = ST_OK;
      end
      pending_headers.push_back(hdr);
      restart();
    endfunction

    function void match_header(logic [RESULT_TDATA_W-1:0] beat);
      wavhp_result_t got;
      wavhp_result_t want;
      got = beat[RESULT_BITS-1:0];
      if (pending_headers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result beat with no finished file: %h", $realtime, beat);
        return;
      end
      want = pending_headers.pop_front();
      if (got !== want || beat[RESULT_TDATA_W-1:RESULT_BITS] !== '0) begin
        failures++;
        if (failures <= 10) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  status   exp %0d got %0d", want.status, got.status);
          $display("  channels exp %0d got %0d", want.channel_count, got.channel_count);
          $display("  rate     exp %0d got %0d", want.sample_rate, got.sample_rate);
          $display("  offset   exp %0d got %0d", want.data_offset, got.data_offset);
          $display("  size     exp %0d got %0d", want.data_size, got.data_size);
          $display("  fill     exp 0 got %h", beat[RESULT_TDATA_W-1:RESULT_BITS]);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block hookup. Every input has a known value from time 0.
  // --------------------------------------------------------------------------
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wen = 1'b0;
  logic [31:0]               cfg_wdata = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata = '0;    // data_byte[7:0]
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  // status[2:0], channel_count[18:3], sample_rate[50:19], data_offset[82:51],
  // data_size[114:83], zero fill above
  logic [RESULT_TDATA_W-1:0] m_tdata;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wav_header_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  wav_header_tracker board = new();

  logic [7:0] wav_bytes[$];   // the file about to be streamed
  int         bytes_sent = 0;
  int         files_sent = 0;
  bit         tx_calm = 1'b0;   // when set, the source sends a file back to back
  bit         long_hold = 1'b0; // asks the sink for one long stall
  int         quiet_cycles = 0;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // File generator. Fields go out little-endian, as they do in a WAV file.
  // --------------------------------------------------------------------------
  function automatic void put_word(logic [31:0] word, int count);
    for (int i = 0; i < count; i++) wav_bytes.push_back(word[8*i +: 8]);
  endfunction

  // A tag with one bit flipped now and then, so the tag checks get hit.
  function automatic logic [31:0] maybe_broken(logic [31:0] tag);
    if ($urandom_range(0, 19) == 0) return tag ^ (32'h1 << $urandom_range(0, 31));
    return tag;
  endfunction

  function automatic void add_chunk(int kind);
    logic [31:0] tag;
    logic [31:0] size;
    int          r;
    int          start;
    r = $urandom_range(0, 99);
    case (kind)
      CK_FMT: begin
        tag = TAG_FMT;
        // Mostly the plain 16-byte body; some extended and some cut short
        // so that only the leading fields lie inside the chunk.
        size = (r < 70) ? 32'd16 : (r < 80) ? 32'd18 : $urandom_range(0, 17);
      end
      CK_DATA: begin
        tag = TAG_DATA;
        size = (r < 15) ? 32'd0 : (r < 85) ? $urandom_range(1, 24) : $urandom_range(25, 60);
      end
      default: begin
        tag = (r < 40) ? TAG_LIST : (r < 70) ? TAG_JUNK : $urandom;
        size = $urandom_range(0, 20);
      end
    endcase
    // A size that overruns the file stops the walk.
    if ($urandom_range(0, 24) == 0) size = $urandom;
    put_word(tag, 4);
    put_word(size, 4);
    start = wav_bytes.size();
    if (kind == CK_FMT) begin
      r = $urandom_range(0, 5);
      put_word(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : 1, 2);
      put_word(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(1, 2), 2);
      put_word((r == 0) ? 32'd8000 : (r == 1) ? 32'd22050 : (r == 2) ? 32'd44100 :
               (r == 3) ? 32'd48000 : (r == 4) ? 32'd96000 : $urandom, 4);
      put_word($urandom, 4);
      put_word($urandom_range(0, 65535), 2);
      r = $urandom_range(0, 9);
      put_word((r < 7) ? 16 : (r == 7) ? 8 : (r == 8) ? 24 : $urandom_range(0, 65535), 2);
      put_word($urandom_range(0, 65535), 2);
      while (wav_bytes.size() > start + size) void'(wav_bytes.pop_back());
    end else begin
      for (int i = 0; i < size && i < 40; i++) wav_bytes.push_back($urandom_range(0, 255));
    end
    if (size[0] && size <= 60) wav_bytes.push_back($urandom_range(0, 255));
  endfunction

  function automatic void build_wav();
    wav_bytes.delete();
    put_word(maybe_broken(TAG_RIFF), 4);
    put_word($urandom, 4);
    put_word(maybe_broken(TAG_WAVE), 4);
    if ($urandom_range(0, 3) != 0) begin
      // The usual layout, sometimes with filler around the fmt chunk and a
      // trailing chunk that may replace the fields kept so far.
      if ($urandom_range(0, 4) == 0) add_chunk(CK_OTHER);
      add_chunk(CK_FMT);
      if ($urandom_range(0, 4) == 0) add_chunk(CK_OTHER);
      add_chunk(CK_DATA);
      if ($urandom_range(0, 5) == 0) add_chunk($urandom_range(CK_FMT, CK_OTHER));
    end else begin
      repeat ($urandom_range(0, 4)) add_chunk($urandom_range(CK_FMT, CK_OTHER));
    end
  endfunction

  // Cut the file or pad it with random bytes to exactly the set length.
  function automatic void fit_wav(logic [31:0] length);
    while (wav_bytes.size() > length) void'(wav_bytes.pop_back());
    while (wav_bytes.size() < length) wav_bytes.push_back($urandom_range(0, 255));
  endfunction

  // --------------------------------------------------------------------------
  // Source side.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] value);
    int gap;
    gap = tx_calm ? 0 : idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    board.absorb_byte(value);
    bytes_sent++;
  endtask

  task automatic push_wav();
    tx_calm = ($urandom_range(0, 3) == 0);
    foreach (wav_bytes[i]) push_byte(wav_bytes[i]);
    files_sent++;
  endtask

  // The length register is only written with the block idle: every result of
  // the files sent so far has come out, and then the pipeline is left to settle.
  task automatic set_file_length(input logic [31:0] value);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.set_length(value);
  endtask

  // One length setting and one or more files of that length. Most files are
  // well formed with random content; the rest are truncated, padded, cut at
  // the header size boundary or plain noise.
  task automatic random_phase();
    int          r;
    int          base;
    logic [31:0] length;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      length = $urandom_range(1, 80);
      set_file_length(length);
      repeat ($urandom_range(1, 3)) begin
        wav_bytes.delete();
        if ($urandom_range(0, 1) == 0) put_word(TAG_RIFF, 4);
        fit_wav(length);
        push_wav();
      end
    end else begin
      build_wav();
      base = wav_bytes.size();
      r = $urandom_range(0, 99);
      if (r < 55) length = base;
      else if (r < 70) length = base + $urandom_range(1, 24);
      else if (r < 90) length = (base > 12) ? base - $urandom_range(1, 12) : 1;
      else length = $urandom_range(MIN_FILE - 1, MIN_FILE);
      set_file_length(length);
      fit_wav(length);
      push_wav();
      if ($urandom_range(0, 2) == 0) begin
        build_wav();
        fit_wav(length);
        push_wav();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sink side: random stalls with calm stretches, plus one long hold on
  // request so that results back up and the block stops taking bytes.
  // --------------------------------------------------------------------------
  initial begin : sink
    int stall;
    int until_switch;
    bit calm;
    stall = 0;
    until_switch = 0;
    calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if (until_switch == 0) begin
          calm = ($urandom_range(0, 3) == 0);
          until_switch = $urandom_range(50, 300);
        end
        until_switch--;
        if (stall > 0) begin
          m_tready <= 1'b0;
          stall--;
        end else begin
          m_tready <= 1'b1;
          if (!calm) stall = idle_gap();
        end
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.match_header(m_tdata);
  end

  // Watchdog: ends the run when nothing has moved on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-byte files: every byte is a whole file with a short-file result.
    // The sink holds off meanwhile, so the block has to stall its input.
    set_file_length(1);
    long_hold = 1'b1;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h55);
    push_byte(8'hAA);
    push_byte(8'h0F);
    push_byte(8'hF0);
    push_byte(8'h33);
    push_byte(8'hCC);

    // Good tags but a file far too short to hold the headers.
    set_file_length(12);
    wav_bytes.delete();
    put_word(TAG_RIFF, 4);
    put_word(32'hFFFF_FFFF, 4);
    put_word(TAG_WAVE, 4);
    push_wav();

    while (bytes_sent < ITEM_TARGET || files_sent < FILE_TARGET) random_phase();

    // Largest nonzero length last: the file never finishes, so no result is due.
    set_file_length(32'hFFFF_FFFF);
    build_wav();
    push_wav();
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
